>>> rtl/fuzzy_traffic_state_classifier_macros.svh
// assertion macros shared by the traffic state classifier rtl
`ifndef FUZZY_TRAFFIC_STATE_CLASSIFIER_MACROS_SVH
`define FUZZY_TRAFFIC_STATE_CLASSIFIER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FTSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define FTSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ftsc_pkg.sv
// shared types, codes and rule base of the traffic state classifier
package ftsc_pkg;

   localparam int VALUE_W = 16;
   localparam int N_MEMB  = 5;

   typedef logic [2:0] class_type;

   localparam class_type CLASS_EMPTY   = 3'd0;
   localparam class_type CLASS_OPEN    = 3'd1;
   localparam class_type CLASS_NORMAL  = 3'd2;
   localparam class_type CLASS_CROWDED = 3'd3;
   localparam class_type CLASS_STOP    = 3'd4;
   localparam class_type CLASS_NA      = 3'd5;
   localparam class_type CLASS_NONE    = 3'd6;

   localparam int              CSR_ADDR_W      = 2;
   localparam logic [1:0]      CSR_HOLD_ADDR   = 2'd0;
   localparam logic [3:0]      HOLD_RESET      = 4'd2;

   // rule base indexed [density membership][speed membership]
   localparam class_type RULE_CLASS [N_MEMB][N_MEMB] = '{
      '{CLASS_EMPTY, CLASS_EMPTY,   CLASS_OPEN,    CLASS_OPEN,   CLASS_OPEN},
      '{CLASS_EMPTY, CLASS_NORMAL,  CLASS_NORMAL,  CLASS_OPEN,   CLASS_OPEN},
      '{CLASS_STOP,  CLASS_NORMAL,  CLASS_NORMAL,  CLASS_OPEN,   CLASS_NA},
      '{CLASS_STOP,  CLASS_CROWDED, CLASS_NORMAL,  CLASS_NORMAL, CLASS_NA},
      '{CLASS_STOP,  CLASS_CROWDED, CLASS_CROWDED, CLASS_NA,     CLASS_NA}
   };

   function automatic class_type rule_class(input logic [2:0] d_idx,
                                            input logic [2:0] s_idx);
      class_type c;
      c = CLASS_EMPTY;
      if (d_idx < 3'(N_MEMB) && s_idx < 3'(N_MEMB)) begin
         c = RULE_CLASS[d_idx][s_idx];
      end
      return c;
   endfunction

endpackage

>>> rtl/ftsc_if.sv
// valid/ready channel interfaces for input items and results
interface ftsc_req_if;
   logic                              valid;
   logic                              ready;
   logic [ftsc_pkg::VALUE_W-1:0]      speed_norm;
   logic [ftsc_pkg::VALUE_W-1:0]      density_norm;

   modport source (output valid, output speed_norm, output density_norm, input ready);
   modport sink   (input valid, input speed_norm, input density_norm, output ready);
endinterface

interface ftsc_rsp_if;
   logic                   valid;
   logic                   ready;
   ftsc_pkg::class_type    class_now;
   logic                   show_pulse;

   modport source (output valid, output class_now, output show_pulse, input ready);
   modport sink   (input valid, input class_now, input show_pulse, output ready);
endinterface

>>> rtl/ftsc_fuzzify.sv
// five-set membership of one input using a bit-serial restoring divider
module ftsc_fuzzify #(
   parameter int                FRAC_BITS = 12,
   parameter logic [4:0][15:0]  KNOTS     = '0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ftsc_pkg::VALUE_W-1:0]   x,
   output logic                           done,
   output logic [2:0]                     idx,
   output logic [FRAC_BITS:0]             m_lo,
   output logic [FRAC_BITS:0]             m_hi
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [15:0]             rem_ff, rem_in;
   logic [15:0]             den_ff, den_in;
   logic [FRAC_BITS-1:0]    q_ff, q_in;
   logic [2:0]              idx_ff, idx_in;
   logic                    full_ff, full_in;

   logic [2:0]              seg;
   logic                    full;
   logic [15:0]             k_lo, k_hi;
   logic [16:0]             trial, diff;
   logic                    ge;
   logic                    rem_nz;

   // locate x: exactly on a set peak or shoulder, or inside a span
   always_comb begin
      full = 1'b1;
      seg  = 3'd0;
      priority if (x <= KNOTS[0]) begin
         seg = 3'd0;
      end else if (x >= KNOTS[4]) begin
         seg = 3'd4;
      end else if (x == KNOTS[1]) begin
         seg = 3'd1;
      end else if (x == KNOTS[2]) begin
         seg = 3'd2;
      end else if (x == KNOTS[3]) begin
         seg = 3'd3;
      end else begin
         full = 1'b0;
         priority if (x < KNOTS[1]) begin
            seg = 3'd0;
         end else if (x < KNOTS[2]) begin
            seg = 3'd1;
         end else if (x < KNOTS[3]) begin
            seg = 3'd2;
         end else begin
            seg = 3'd3;
         end
      end
   end

   always_comb begin
      unique case (seg[1:0])
         2'd0: begin k_lo = KNOTS[0]; k_hi = KNOTS[1]; end
         2'd1: begin k_lo = KNOTS[1]; k_hi = KNOTS[2]; end
         2'd2: begin k_lo = KNOTS[2]; k_hi = KNOTS[3]; end
         2'd3: begin k_lo = KNOTS[3]; k_hi = KNOTS[4]; end
         default: begin k_lo = KNOTS[0]; k_hi = KNOTS[1]; end
      endcase
   end

   assign trial = {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      idx_in  = idx_ff;
      full_in = full_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRAC_BITS);
         rem_in  = x - k_lo;
         den_in  = k_hi - k_lo;
         idx_in  = seg;
         full_in = full;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = ge ? diff[15:0] : trial[15:0];
         q_in   = {q_ff[FRAC_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      idx_ff  <= idx_in;
      full_ff <= full_in;
   end

   // falling side from the rising quotient: one minus q, less one on a remainder
   assign rem_nz = rem_ff != 16'd0;
   assign done   = done_ff;
   assign idx    = idx_ff;
   assign m_hi   = full_ff ? '0 : {1'b0, q_ff};
   assign m_lo   = full_ff ? ONE
                 : ONE - {1'b0, q_ff} - {{FRAC_BITS{1'b0}}, rem_nz};

endmodule

>>> rtl/fuzzy_traffic_state_classifier.sv
// an input beat is taken only while idle; it passes through the bit-serial membership
//   dividers (one quotient bit per cycle) and the four rule products with their max,
//   then waits in S_DONE while the output register holds a result not yet accepted
// a finished result waits in the output register while the next item is taken
// reset (synchronous, high): idle, no result held, hold_frames 2, no tracked class, run 0
`include "fuzzy_traffic_state_classifier_macros.svh"

module fuzzy_traffic_state_classifier #(
   parameter int VALUE_FRAC_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ftsc_req_if.sink                               req_ch,
   ftsc_rsp_if.source                             rsp_ch,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [ftsc_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int F      = VALUE_FRAC_BITS;
   localparam int MEMB_W = F + 1;
   localparam int PROD_W = 2 * MEMB_W;

   // breakpoints, round half up
   localparam logic [15:0] SP_K0 = 16'(((3 << F) + 20) / 40);
   localparam logic [15:0] SP_K1 = 16'(((3 << F) + 10) / 20);
   localparam logic [15:0] SP_K2 = 16'(((1 << F) + 2) / 4);
   localparam logic [15:0] SP_K3 = 16'(((1 << F) + 1) / 2);
   localparam logic [15:0] SP_K4 = 16'(((3 << F) + 2) / 4);
   localparam logic [15:0] DS_K0 = 16'(((1 << F) + 5) / 10);
   localparam logic [15:0] DS_K1 = 16'(((1 << F) + 2) / 5);
   localparam logic [15:0] DS_K2 = 16'(((2 << F) + 2) / 5);
   localparam logic [15:0] DS_K3 = 16'(((1 << F) + 1) / 2);
   localparam logic [15:0] DS_K4 = 16'(((3 << F) + 2) / 5);
   localparam logic [4:0][15:0] SP_KNOTS = {SP_K4, SP_K3, SP_K2, SP_K1, SP_K0};
   localparam logic [4:0][15:0] DS_KNOTS = {DS_K4, DS_K3, DS_K2, DS_K1, DS_K0};

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [2:0] MUL_LAST = 3'd4;

   logic [1:0]                state_ff, state_in;
   logic [2:0]                mul_cnt_ff, mul_cnt_in;
   logic [PROD_W-1:0]         best_p_ff, best_p_in;
   ftsc_pkg::class_type       best_c_ff, best_c_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   ftsc_pkg::class_type       prod_cls_ff, prod_cls_in;
   logic [3:0]                hold_ff, hold_in;
   ftsc_pkg::class_type       tracked_ff, tracked_in;
   logic [3:0]                run_ff, run_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ftsc_pkg::class_type       class_ff, class_in;
   logic                      pulse_ff, pulse_in;

   logic                      start;
   logic                      sp_done, ds_done;
   logic [2:0]                sp_idx, ds_idx;
   logic [MEMB_W-1:0]         sp_mlo, sp_mhi, ds_mlo, ds_mhi;
   logic [1:0]                pair;
   logic [2:0]                d_idx, s_idx;
   logic [MEMB_W-1:0]         md, ms;
   logic                      better;
   logic                      rsp_load;
   logic [3:0]                run_new;
   logic                      csr_wr;

   assign start = req_ch.valid && (state_ff == S_IDLE);

   ftsc_fuzzify #(
      .FRAC_BITS (F),
      .KNOTS     (SP_KNOTS)
   ) u_speed (
      .clock (clock),
      .reset (reset),
      .start (start),
      .x     (req_ch.speed_norm),
      .done  (sp_done),
      .idx   (sp_idx),
      .m_lo  (sp_mlo),
      .m_hi  (sp_mhi)
   );

   ftsc_fuzzify #(
      .FRAC_BITS (F),
      .KNOTS     (DS_KNOTS)
   ) u_density (
      .clock (clock),
      .reset (reset),
      .start (start),
      .x     (req_ch.density_norm),
      .done  (ds_done),
      .idx   (ds_idx),
      .m_lo  (ds_mlo),
      .m_hi  (ds_mhi)
   );

   // each input has at most two adjacent nonzero sets: four rule products
   assign pair  = mul_cnt_ff[1:0];
   assign d_idx = ds_idx + {2'b00, pair[1]};
   assign s_idx = sp_idx + {2'b00, pair[0]};
   assign md    = pair[1] ? ds_mhi : ds_mlo;
   assign ms    = pair[0] ? sp_mhi : sp_mlo;

   // strongest product wins, lower class on a tie; nothing above zero leaves class 0
   assign better = (prod_ff > best_p_ff)
                || ((prod_ff == best_p_ff) && (prod_cls_ff < best_c_ff));

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign csr_wr = psel && penable && pwrite && (paddr == ftsc_pkg::CSR_HOLD_ADDR);

   always_comb begin
      state_in     = state_ff;
      mul_cnt_in   = mul_cnt_ff;
      best_p_in    = best_p_ff;
      best_c_in    = best_c_ff;
      prod_in      = PROD_W'(md) * PROD_W'(ms);
      prod_cls_in  = ftsc_pkg::rule_class(d_idx, s_idx);
      hold_in      = csr_wr ? pwdata[3:0] : hold_ff;
      tracked_in   = tracked_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      class_in     = class_ff;
      pulse_in     = 1'b0;
      run_new      = run_ff + 4'd1;

      if (best_c_ff != tracked_ff) begin
         run_new = 4'd0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in  = S_DIV;
               best_p_in = '0;
               best_c_in = ftsc_pkg::CLASS_EMPTY;
            end
         end
         S_DIV: begin
            if (sp_done) begin
               state_in   = S_MUL;
               mul_cnt_in = 3'd0;
            end
         end
         S_MUL: begin
            if (mul_cnt_ff != 3'd0 && better) begin
               best_p_in = prod_ff;
               best_c_in = prod_cls_ff;
            end
            mul_cnt_in = mul_cnt_ff + 3'd1;
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            pulse_in = run_new == hold_ff;
            if (rsp_load) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               class_in     = best_c_ff;
               tracked_in   = best_c_ff;
               run_in       = pulse_in ? 4'd0 : run_new;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_cnt_ff   <= 3'd0;
         hold_ff      <= ftsc_pkg::HOLD_RESET;
         tracked_ff   <= ftsc_pkg::CLASS_NONE;
         run_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_cnt_ff   <= mul_cnt_in;
         hold_ff      <= hold_in;
         tracked_ff   <= tracked_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_p_ff   <= best_p_in;
      best_c_ff   <= best_c_in;
      prod_ff     <= prod_in;
      prod_cls_ff <= prod_cls_in;
      if (rsp_load) begin
         class_ff <= class_in;
         pulse_ff <= pulse_in;
      end
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.class_now  = class_ff;
   assign rsp_ch.show_pulse = pulse_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == ftsc_pkg::CSR_HOLD_ADDR) ? {28'd0, hold_ff} : 32'd0;

   `FTSC_ASSERT_SAME(a_fuzz_in_step, clock, reset, sp_done, ds_done && state_ff == S_DIV, "membership units out of step")
   `FTSC_ASSERT_SAME(a_tracked_after_result, clock, reset, rsp_valid_ff, tracked_ff != ftsc_pkg::CLASS_NONE, "result shown with no tracked class")
   `FTSC_ASSERT_SAME(a_winner_range, clock, reset, state_ff == S_DONE, best_c_ff <= ftsc_pkg::CLASS_NA, "winning class out of range")
   `FTSC_ASSERT_NEXT(a_pulse_clears_run, clock, reset, rsp_load && pulse_in, run_ff == 4'd0 && rsp_ch.show_pulse, "run count not cleared on pulse")

endmodule
